// ===== rtl/vmu_pkg.sv =====
package vmu_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned IdxW = 10;
  localparam int unsigned CountW = 11;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [4:0] OP_VMANDN  = 5'd0;
  localparam logic [4:0] OP_VMAND   = 5'd1;
  localparam logic [4:0] OP_VMOR    = 5'd2;
  localparam logic [4:0] OP_VMXOR   = 5'd3;
  localparam logic [4:0] OP_VMORN   = 5'd4;
  localparam logic [4:0] OP_VMNAND  = 5'd5;
  localparam logic [4:0] OP_VMNOR   = 5'd6;
  localparam logic [4:0] OP_VMXNOR  = 5'd7;
  localparam logic [4:0] OP_VMV_S_X = 5'd8;
  localparam logic [4:0] OP_VMV_X_S = 5'd9;
  localparam logic [4:0] OP_VCPOP   = 5'd10;
  localparam logic [4:0] OP_VFIRST  = 5'd11;
  localparam logic [4:0] OP_VZEXT8  = 5'd12;
  localparam logic [4:0] OP_VSEXT8  = 5'd13;
  localparam logic [4:0] OP_VZEXT4  = 5'd14;
  localparam logic [4:0] OP_VSEXT4  = 5'd15;
  localparam logic [4:0] OP_VZEXT2  = 5'd16;
  localparam logic [4:0] OP_VSEXT2  = 5'd17;
  localparam logic [4:0] OP_VMSBF   = 5'd18;
  localparam logic [4:0] OP_VMSOF   = 5'd19;
  localparam logic [4:0] OP_VMSIF   = 5'd20;
  localparam logic [4:0] OP_VIOTA   = 5'd21;
  localparam logic [4:0] OP_VID     = 5'd22;

  typedef enum logic [3:0] {
    CL_NONE,
    CL_LOGIC,
    CL_MVSX,
    CL_MVXS,
    CL_CPOP,
    CL_FIRST,
    CL_EXT,
    CL_SCAN,
    CL_IOTA,
    CL_VID
  } op_class_t;

  typedef enum logic [1:0] {
    SCAN_BF,
    SCAN_OF,
    SCAN_IF
  } scan_kind_t;

  typedef struct packed {
    op_class_t        cls;
    logic [IdxW-1:0]  idx;
    logic             first;
    logic             last;
    logic             present;
    logic             active;
    logic             a;
    logic             logic_bit;
    logic [1:0]       ext_shift;
    logic             ext_sgn;
    scan_kind_t       scan;
    logic [63:0]      val;
  } front_item_t;

  typedef struct packed {
    logic        we;
    logic        rbit;
    logic [63:0] relem;
    logic        sv;
    logic [63:0] sout;
  } result_t;

  function automatic logic [63:0] width_mask(input logic [1:0] code);
    logic [63:0] m;
    case (code)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [1:0] code);
    logic [63:0] r;
    case (code)
      2'd0:    r = {{56{v[7]}}, v[7:0]};
      2'd1:    r = {{48{v[15]}}, v[15:0]};
      2'd2:    r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/vmu_fifo.sv =====
module vmu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] in_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] out_data,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CntW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign out_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/vmu_front.sv =====
module vmu_front (
  input  logic [4:0]          op,
  input  logic [9:0]          elem_index,
  input  logic                first_item,
  input  logic                last_item,
  input  logic                present,
  input  logic                mask_a,
  input  logic                mask_b,
  input  logic                v0_bit,
  input  logic                unmasked,
  input  logic [63:0]         operand_value,
  output vmu_pkg::front_item_t item
);

  import vmu_pkg::*;

  logic in_range;
  logic pres;

  assign in_range = ({7'd0, elem_index} < 17'(MaxElements));
  assign pres     = present && in_range;

  always_comb begin
    item           = '0;
    item.cls       = CL_NONE;
    item.scan      = SCAN_BF;
    item.idx       = elem_index;
    item.first     = first_item;
    item.last      = last_item;
    item.present   = pres;
    item.active    = pres && (unmasked || v0_bit);
    item.a         = mask_a;
    item.val       = operand_value;
    item.ext_sgn   = op[0];
    case (op)
      OP_VMANDN: item.logic_bit = mask_a && !mask_b;
      OP_VMAND:  item.logic_bit = mask_a && mask_b;
      OP_VMOR:   item.logic_bit = mask_a || mask_b;
      OP_VMXOR:  item.logic_bit = mask_a ^ mask_b;
      OP_VMORN:  item.logic_bit = mask_a || !mask_b;
      OP_VMNAND: item.logic_bit = !(mask_a && mask_b);
      OP_VMNOR:  item.logic_bit = !(mask_a || mask_b);
      default:   item.logic_bit = !(mask_a ^ mask_b);
    endcase
    case (op) inside
      [OP_VMANDN:OP_VMXNOR]: item.cls = CL_LOGIC;
      OP_VMV_S_X:            item.cls = CL_MVSX;
      OP_VMV_X_S:            item.cls = CL_MVXS;
      OP_VCPOP:              item.cls = CL_CPOP;
      OP_VFIRST:             item.cls = CL_FIRST;
      OP_VZEXT8, OP_VSEXT8: begin
        item.cls       = CL_EXT;
        item.ext_shift = 2'd3;
      end
      OP_VZEXT4, OP_VSEXT4: begin
        item.cls       = CL_EXT;
        item.ext_shift = 2'd2;
      end
      OP_VZEXT2, OP_VSEXT2: begin
        item.cls       = CL_EXT;
        item.ext_shift = 2'd1;
      end
      OP_VMSBF: begin
        item.cls  = CL_SCAN;
        item.scan = SCAN_BF;
      end
      OP_VMSOF: begin
        item.cls  = CL_SCAN;
        item.scan = SCAN_OF;
      end
      OP_VMSIF: begin
        item.cls  = CL_SCAN;
        item.scan = SCAN_IF;
      end
      OP_VIOTA:              item.cls = CL_IOTA;
      OP_VID:                item.cls = CL_VID;
      default:               item.cls = CL_NONE;
    endcase
  end

endmodule

// ===== rtl/vmu_back.sv =====
module vmu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           sew_code,
  input  logic                 item_valid,
  input  vmu_pkg::front_item_t item,
  output logic                 item_take,
  output logic                 res_push,
  output vmu_pkg::result_t     res,
  input  logic                 res_full
);

  import vmu_pkg::*;

  logic              found;
  logic [CountW-1:0] count;
  logic [IdxW-1:0]   first_idx;
  logic              seen;

  logic              found_cur;
  logic [CountW-1:0] count_cur;
  logic [IdxW-1:0]   first_idx_cur;
  logic              seen_cur;

  logic              found_next;
  logic [CountW-1:0] count_next;
  logic [IdxW-1:0]   first_idx_next;
  logic              seen_next;

  logic [63:0]       emask;
  logic [1:0]        src_code;
  logic              can_inc;

  assign item_take = item_valid && !res_full;
  assign res_push  = item_take;
  assign emask     = width_mask(sew_code);
  assign src_code  = sew_code - item.ext_shift;

  always_comb begin
    found_cur     = item.first ? 1'b0 : found;
    count_cur     = item.first ? '0 : count;
    first_idx_cur = item.first ? '0 : first_idx;
    seen_cur      = item.first ? 1'b0 : seen;
    can_inc       = (count_cur != CountMax);

    found_next     = found_cur;
    count_next     = count_cur;
    first_idx_next = first_idx_cur;
    seen_next      = seen_cur;
    res            = '0;

    case (item.cls)
      CL_LOGIC: begin
        res.we   = item.present;
        res.rbit = item.present && item.logic_bit;
      end
      CL_MVSX: begin
        if (item.present && item.idx == '0) begin
          res.we    = 1'b1;
          res.relem = item.val & emask;
        end
      end
      CL_MVXS: begin
        res.sv   = item.last;
        res.sout = item.last ? sign_ext(item.val, sew_code) : '0;
      end
      CL_CPOP: begin
        if (item.active && item.a && can_inc) begin
          count_next = count_cur + 1'b1;
        end
        res.sv   = item.last;
        res.sout = item.last ? {{(64 - CountW){1'b0}}, count_next} : '0;
      end
      CL_FIRST: begin
        if (item.active && item.a && !seen_cur) begin
          seen_next      = 1'b1;
          first_idx_next = item.idx;
        end
        if (item.last) begin
          res.sv   = 1'b1;
          res.sout = seen_next ? {{(64 - IdxW){1'b0}}, first_idx_next} : '1;
        end
      end
      CL_EXT: begin
        if (sew_code >= item.ext_shift && item.active) begin
          res.we    = 1'b1;
          res.relem = item.ext_sgn ? (sign_ext(item.val, src_code) & emask)
                                   : (item.val & width_mask(src_code));
        end
      end
      CL_SCAN: begin
        if (item.active) begin
          res.we     = 1'b1;
          found_next = found_cur || item.a;
          case (item.scan)
            SCAN_BF: res.rbit = !found_cur && !item.a;
            SCAN_OF: res.rbit = !found_cur && item.a;
            default: res.rbit = !found_cur;
          endcase
        end
      end
      CL_IOTA: begin
        if (item.active) begin
          res.we    = 1'b1;
          res.relem = {{(64 - CountW){1'b0}}, count_cur} & emask;
          if (item.a && can_inc) begin
            count_next = count_cur + 1'b1;
          end
        end
      end
      CL_VID: begin
        if (item.active) begin
          res.we    = 1'b1;
          res.relem = {{(64 - IdxW){1'b0}}, item.idx} & emask;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      count     <= '0;
      first_idx <= '0;
      seen      <= 1'b0;
    end else if (item_take) begin
      found     <= found_next;
      count     <= count_next;
      first_idx <= first_idx_next;
      seen      <= seen_next;
    end
  end

endmodule

// ===== rtl/vector_mask_unary_unit.sv =====
// Element-serial vector mask and unary unit.
// Input queue: drive one element beat with push while full is low; the beat
// carries op, elem_index, first_item, last_item, present, mask bits, the v0
// bit, unmasked and operand_value. Set first_item on the first beat of an
// instruction to clear the found flag, running count and first index.
// Result queue: while empty is low the oldest result is on write_enable,
// result_bit, result_elem, scalar_valid and scalar_out; pop takes it.
// Every input beat yields exactly one result beat, in order.
// Configuration: cfg_data (element width code) is taken when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// A beat is held in the decoder queue and its result in the result queue.
// Throughput: one beat per cycle while the result queue is not full, set by
// the back-end state update. A two-entry queue after the decoder and a
// two-entry result queue let the input side keep running while a result
// waits; if pop stays low, full rises after four beats are held and stays
// until a pop. Reset empties both queues, clears the running state and sets
// the element width code to 8 bits.
module vector_mask_unary_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  op,
  input  logic [9:0]  elem_index,
  input  logic        first_item,
  input  logic        last_item,
  input  logic        present,
  input  logic        mask_a,
  input  logic        mask_b,
  input  logic        v0_bit,
  input  logic        unmasked,
  input  logic [63:0] operand_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic        write_enable,
  output logic        result_bit,
  output logic [63:0] result_elem,
  output logic        scalar_valid,
  output logic [63:0] scalar_out
);

  import vmu_pkg::*;

  localparam int QueueDepth = 2;

  logic [1:0]  sew_code;
  front_item_t front_item;
  front_item_t mid_item;
  logic        mid_empty;
  logic        mid_take;
  logic        res_push;
  logic        res_full;
  result_t     back_res;
  result_t     out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sew_code <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      sew_code <= cfg_data;
    end
  end

  vmu_front u_front (
    .op            (op),
    .elem_index    (elem_index),
    .first_item    (first_item),
    .last_item     (last_item),
    .present       (present),
    .mask_a        (mask_a),
    .mask_b        (mask_b),
    .v0_bit        (v0_bit),
    .unmasked      (unmasked),
    .operand_value (operand_value),
    .item          (front_item)
  );

  vmu_fifo #(
    .WIDTH ($bits(front_item_t)),
    .DEPTH (QueueDepth)
  ) u_mid_q (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_data  (front_item),
    .full     (full),
    .pop      (mid_take),
    .out_data (mid_item),
    .empty    (mid_empty)
  );

  vmu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .sew_code   (sew_code),
    .item_valid (!mid_empty),
    .item       (mid_item),
    .item_take  (mid_take),
    .res_push   (res_push),
    .res        (back_res),
    .res_full   (res_full)
  );

  vmu_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QueueDepth)
  ) u_res_q (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .in_data  (back_res),
    .full     (res_full),
    .pop      (pop),
    .out_data (out_res),
    .empty    (empty)
  );

  assign write_enable = out_res.we;
  assign result_bit   = out_res.rbit;
  assign result_elem  = out_res.relem;
  assign scalar_valid = out_res.sv;
  assign scalar_out   = out_res.sout;

endmodule
